// ===== hdl/tfl_pkg.sv =====
// ---------------------------------------------------------------------------
// tfl_pkg
// Shared types and constants of the torch/flash LED owner control unit.
// ---------------------------------------------------------------------------
`default_nettype none

package tfl_pkg;

   localparam int MA_W    = 10;   // request current width
   localparam int THR_W   = 10;   // threshold register width
   localparam int BASE_W  = 6;    // mA/25 less one, at most 39
   localparam int CODE_W  = 9;    // drive code width
   localparam int ADDR_W  = 3;    // csr byte address width
   localparam int DATA_W  = 32;   // csr data width

   localparam logic [THR_W-1:0] CAMERA_THR_RESET = THR_W'(250);
   localparam logic [THR_W-1:0] COMM_THR_RESET   = THR_W'(100);

   // Register indexes, taken from csr address bit 2
   localparam logic REG_CAMERA_THR = 1'b0;
   localparam logic REG_COMM_THR   = 1'b1;

   // Requester codes
   localparam logic MODE_CAMERA = 1'b0;
   localparam logic MODE_COMM   = 1'b1;

   // mA/25 as (mA * 1311) >> 15, exact for 10-bit currents
   localparam int DIV25_MUL   = 1311;
   localparam int DIV25_SHIFT = 15;

   // ceil(b*1000/79) as (b*1000+78)*53093 >> 22
   localparam logic [31:0] FLASH_MUL   = 32'd53093000;
   localparam logic [31:0] FLASH_ADD   = 32'd4141254;
   localparam int          FLASH_SHIFT = 22;

   // ceil(b*200/15) as (b*200+14)*8739 >> 17
   localparam logic [31:0] TORCH_MUL   = 32'd1747800;
   localparam logic [31:0] TORCH_ADD   = 32'd122346;
   localparam int          TORCH_SHIFT = 17;

   localparam logic [CODE_W-1:0] CODE_MAX = '1;
   localparam logic [CODE_W-1:0] CODE_MIN = CODE_W'(1);

   // Request after the front stage
   typedef struct packed {
      logic              mode;
      logic              ma_zero;
      logic              flash;
      logic [BASE_W-1:0] base;
   } item_type;

endpackage

`default_nettype wire

// ===== hdl/torch_flash_led_owner_control_unit.sv =====
// ---------------------------------------------------------------------------
// torch_flash_led_owner_control_unit
// Torch/flash LED drive control shared by a camera and a comm requester.
// ---------------------------------------------------------------------------
// Each request (requester in tuser, current in mA in tdata) yields one
// response with the flash and torch drive state and both owner flags as they
// stand after the request. Requests pass an input register, where the current
// is divided by 25 and compared with the requester's flash threshold, then the
// drive code scaling and owner rules, whose state register is the response
// register. One request is taken every cycle while responses are drained.
// Thresholds are written over the csr port; the user must write them only
// while no request is in flight, as the block does not enforce this.
`default_nettype none

module torch_flash_led_owner_control_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,   // [9:0] milliamps
   input  wire logic                       req_tuser,   // [0] mode
   // response
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [23:0]                rsp_tdata,
   // [0] flash_active, [9:1] flash_level, [10] torch_active,
   // [19:11] torch_level, [20] camera_owns, [21] comm_owns
   // csr
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [tfl_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [tfl_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [tfl_pkg::DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [tfl_pkg::THR_W-1:0] camera_thr;
   logic [tfl_pkg::THR_W-1:0] comm_thr;
   logic                      take;
   logic                      item_valid;
   tfl_pkg::item_type         item;

   tfl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .camera_thr  (camera_thr),
      .comm_thr    (comm_thr)
   );

   tfl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .camera_thr (camera_thr),
      .comm_thr   (comm_thr),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   tfl_owner u_owner (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hdl/tfl_csr.sv =====
// ---------------------------------------------------------------------------
// tfl_csr
// Threshold registers behind a simple APB-style port.
// ---------------------------------------------------------------------------
`default_nettype none

module tfl_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [tfl_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [tfl_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [tfl_pkg::DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic      [tfl_pkg::THR_W-1:0]   camera_thr,
   output logic      [tfl_pkg::THR_W-1:0]   comm_thr
);

   logic [tfl_pkg::THR_W-1:0] camera_thr_ff, camera_thr_in;
   logic [tfl_pkg::THR_W-1:0] comm_thr_ff, comm_thr_in;
   logic                      wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      camera_thr_in = camera_thr_ff;
      comm_thr_in   = comm_thr_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            tfl_pkg::REG_CAMERA_THR: camera_thr_in = csr_pwdata[tfl_pkg::THR_W-1:0];
            tfl_pkg::REG_COMM_THR:   comm_thr_in   = csr_pwdata[tfl_pkg::THR_W-1:0];
            default:                 camera_thr_in = camera_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_thr_ff <= tfl_pkg::CAMERA_THR_RESET;
         comm_thr_ff   <= tfl_pkg::COMM_THR_RESET;
      end else begin
         camera_thr_ff <= camera_thr_in;
         comm_thr_ff   <= comm_thr_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         tfl_pkg::REG_CAMERA_THR:
            csr_prdata = {{(tfl_pkg::DATA_W-tfl_pkg::THR_W){1'b0}}, camera_thr_ff};
         tfl_pkg::REG_COMM_THR:
            csr_prdata = {{(tfl_pkg::DATA_W-tfl_pkg::THR_W){1'b0}}, comm_thr_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   assign camera_thr = camera_thr_ff;
   assign comm_thr   = comm_thr_ff;

endmodule

`default_nettype wire

// ===== hdl/tfl_front.sv =====
// ---------------------------------------------------------------------------
// tfl_front
// Input register: takes a request, divides the current by 25 and compares
// it against the requester's flash threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module tfl_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,
   input  wire logic                       req_tuser,
   input  wire logic [tfl_pkg::THR_W-1:0]  camera_thr,
   input  wire logic [tfl_pkg::THR_W-1:0]  comm_thr,
   input  wire logic                       take,
   output logic                            item_valid,
   output tfl_pkg::item_type               item
);

   logic                    valid_ff, valid_in;
   tfl_pkg::item_type       item_ff, item_in;
   logic [tfl_pkg::MA_W-1:0]  ma;
   logic [tfl_pkg::THR_W-1:0] thr;
   logic [20:0]             prod;
   logic [5:0]              quot;
   logic                    accept;

   assign ma         = req_tdata[tfl_pkg::MA_W-1:0];
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      thr  = (req_tuser == tfl_pkg::MODE_COMM) ? comm_thr : camera_thr;
      prod = 21'(ma) * 21'(tfl_pkg::DIV25_MUL);
      quot = prod[tfl_pkg::DIV25_SHIFT +: 6];

      item_in.mode    = req_tuser;
      item_in.ma_zero = (ma == '0);
      item_in.flash   = (ma > thr);
      item_in.base    = (quot > 6'd1) ? quot - 6'd1 : '0;
   end

   always_comb begin
      priority if (accept) valid_in = 1'b1;
      else if (take)       valid_in = 1'b0;
      else                 valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hdl/tfl_owner.sv =====
// ---------------------------------------------------------------------------
// tfl_owner
// Drive code scaling, owner rules and the light state, which doubles as the
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tfl_owner (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire tfl_pkg::item_type   item,
   output logic                     take,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [23:0]              rsp_tdata
);

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        flash_on_ff, flash_on_in;
   logic                        torch_on_ff, torch_on_in;
   logic [tfl_pkg::CODE_W-1:0]  level_ff, level_in;
   logic                        camera_owner_ff, camera_owner_in;
   logic                        comm_owner_ff, comm_owner_in;
   logic [31:0]                 prod;
   logic [9:0]                  raw_code;
   logic [tfl_pkg::CODE_W-1:0]  code;
   logic                        turn_on, turn_off;

   assign take = item_valid && (!rsp_valid_ff || rsp_tready);

   // ceil-scaled drive code, then clamp to 1..511
   always_comb begin
      if (item.flash) begin
         prod     = 32'(item.base) * tfl_pkg::FLASH_MUL + tfl_pkg::FLASH_ADD;
         raw_code = prod[tfl_pkg::FLASH_SHIFT +: 10];
      end else begin
         prod     = 32'(item.base) * tfl_pkg::TORCH_MUL + tfl_pkg::TORCH_ADD;
         raw_code = prod[tfl_pkg::TORCH_SHIFT +: 10];
      end
      priority if (raw_code == '0)      code = tfl_pkg::CODE_MIN;
      else if (raw_code[9])             code = tfl_pkg::CODE_MAX;
      else                              code = raw_code[tfl_pkg::CODE_W-1:0];
   end

   always_comb begin
      camera_owner_in = camera_owner_ff;
      comm_owner_in   = comm_owner_ff;
      turn_on         = 1'b0;
      turn_off        = 1'b0;

      unique case (item.mode)
         tfl_pkg::MODE_CAMERA: begin
            if (item.ma_zero) begin
               if (camera_owner_ff != comm_owner_ff) begin
                  turn_off        = 1'b1;
                  camera_owner_in = 1'b0;
               end
            end else begin
               turn_on = 1'b1;
               if (!camera_owner_ff) begin
                  comm_owner_in   = 1'b0;
                  camera_owner_in = 1'b1;
               end
            end
         end
         tfl_pkg::MODE_COMM: begin
            if (item.ma_zero) begin
               if (!camera_owner_ff && comm_owner_ff) begin
                  turn_off      = 1'b1;
                  comm_owner_in = 1'b0;
               end
            end else if (!camera_owner_ff && !comm_owner_ff) begin
               turn_on       = 1'b1;
               comm_owner_in = 1'b1;
            end
         end
         default: turn_on = 1'b0;
      endcase

      priority if (turn_on) begin
         flash_on_in = item.flash;
         torch_on_in = !item.flash;
         level_in    = code;
      end else if (turn_off) begin
         flash_on_in = 1'b0;
         torch_on_in = 1'b0;
         level_in    = '0;
      end else begin
         flash_on_in = flash_on_ff;
         torch_on_in = torch_on_ff;
         level_in    = level_ff;
      end
   end

   always_comb begin
      priority if (take)     rsp_valid_in = 1'b1;
      else if (rsp_tready)   rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         flash_on_ff     <= 1'b0;
         torch_on_ff     <= 1'b0;
         level_ff        <= '0;
         camera_owner_ff <= 1'b0;
         comm_owner_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            flash_on_ff     <= flash_on_in;
            torch_on_ff     <= torch_on_in;
            level_ff        <= level_in;
            camera_owner_ff <= camera_owner_in;
            comm_owner_ff   <= comm_owner_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        comm_owner_ff,
                        camera_owner_ff,
                        torch_on_ff ? level_ff : {tfl_pkg::CODE_W{1'b0}},
                        torch_on_ff,
                        flash_on_ff ? level_ff : {tfl_pkg::CODE_W{1'b0}},
                        flash_on_ff};

endmodule

`default_nettype wire
